// ===== hdl/dnle_pkg.sv =====
// shared types and constants for the dns name label encoder
// used by dnle_ctrl, dnle_datapath and dns_name_label_encoder_unit; no dependencies
package dnle_pkg;

    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned MAX_LABEL = 63;
    localparam int unsigned MAX_NAME  = 255;
    localparam int unsigned BUS_BYTES = 8;

    localparam int unsigned LEN_W     = $clog2(MAX_LABEL + 1);
    localparam int unsigned TOTAL_W   = 9;
    localparam int unsigned TOTAL_SAT = (1 << TOTAL_W) - 1;
    // length byte, label, terminator
    localparam int unsigned NB_W      = $clog2(MAX_LABEL + 3);
    localparam int unsigned LANE_W    = $clog2(BUS_BYTES);
    // buffer positions 0..MAX_LABEL, position 0 is the length byte slot
    localparam int unsigned ROWS      = (MAX_LABEL + BUS_BYTES) / BUS_BYTES;
    localparam int unsigned ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int unsigned WIDX_W    = $clog2((MAX_LABEL + 2) / BUS_BYTES + 2);
    localparam int unsigned WORD_W    = BUS_BYTES * CHAR_W;
    localparam int unsigned CNT_W     = 4;

    localparam logic [CHAR_W-1:0] SEP_CHAR = 8'h2E;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_LABEL = 2'd1,
        ERR_NAME  = 2'd2
    } err_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_READ,
        CS_LOAD,
        CS_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic take;
        logic fetch;
        logic load_word;
        logic advance;
    } dp_cmd_t;

    typedef struct packed {
        logic emit;
        logic err_out;
        logic last_word;
    } dp_stat_t;

endpackage

// ===== hdl/dns_name_label_encoder_unit.sv =====
// dns name label encoder top level: controller plus datapath, uses dnle_pkg
// flow: a flushing transaction is taken while idle; each result word then passes row read,
//   word assembly and output; a failed name goes straight out as a single status word
// input: a plain character is taken whenever idle; s_tready is low while a flush emits
//   up to 9 words or a failed name's status word, each held on m_tvalid until m_tready
// reset: aresetn synchronous, active low; clears state, lengths and error, not the buffer
module dns_name_label_encoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [63:0] out_word, [67:64] byte_count, [71:68] zero
    output logic        m_tlast,   // name_done
    output logic [1:0]  m_tuser    // [1:0] status
);

    dnle_pkg::dp_cmd_t  cmd;
    dnle_pkg::dp_stat_t stat;
    logic [dnle_pkg::WORD_W-1:0] out_word;
    logic [dnle_pkg::CNT_W-1:0]  byte_count;
    dnle_pkg::err_t              status;

    dnle_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dnle_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .char_in    (s_tdata),
        .is_last    (s_tlast),
        .out_word   (out_word),
        .byte_count (byte_count),
        .name_done  (m_tlast),
        .status     (status)
    );

    assign m_tdata = {4'b0000, byte_count, out_word};
    assign m_tuser = status;

endmodule

// ===== hdl/dnle_ctrl.sv =====
// controller state machine of the dns name label encoder
// depends on dnle_pkg
module dnle_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  dnle_pkg::dp_stat_t stat,
    output dnle_pkg::dp_cmd_t  cmd
);

    dnle_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dnle_pkg::CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dnle_pkg::CS_IDLE: begin
                if (s_tvalid) begin
                    if (stat.emit) begin
                        state_next = dnle_pkg::CS_READ;
                    end else if (stat.err_out) begin
                        state_next = dnle_pkg::CS_OUT;
                    end
                end
            end
            dnle_pkg::CS_READ: state_next = dnle_pkg::CS_LOAD;
            dnle_pkg::CS_LOAD: state_next = dnle_pkg::CS_OUT;
            dnle_pkg::CS_OUT: begin
                if (m_tready) begin
                    state_next = stat.last_word ? dnle_pkg::CS_IDLE : dnle_pkg::CS_READ;
                end
            end
            default: state_next = dnle_pkg::CS_IDLE;
        endcase
    end

    always_comb begin
        s_tready      = (state_reg == dnle_pkg::CS_IDLE);
        m_tvalid      = (state_reg == dnle_pkg::CS_OUT);
        cmd.take      = (state_reg == dnle_pkg::CS_IDLE) && s_tvalid;
        cmd.fetch     = (state_reg == dnle_pkg::CS_READ);
        cmd.load_word = (state_reg == dnle_pkg::CS_LOAD);
        cmd.advance   = (state_reg == dnle_pkg::CS_OUT) && m_tready;
    end

endmodule

// ===== hdl/dnle_datapath.sv =====
// datapath of the dns name label encoder: label buffer, length and error
// tracking, word assembly and output register; depends on dnle_pkg
module dnle_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  dnle_pkg::dp_cmd_t                cmd,
    output dnle_pkg::dp_stat_t               stat,
    input  logic [dnle_pkg::CHAR_W-1:0]      char_in,
    input  logic                             is_last,
    output logic [dnle_pkg::WORD_W-1:0]      out_word,
    output logic [dnle_pkg::CNT_W-1:0]       byte_count,
    output logic                             name_done,
    output dnle_pkg::err_t                   status
);

    // label buffer, byte lanes; position p holds label byte p-1
    logic [dnle_pkg::BUS_BYTES-1:0][dnle_pkg::CHAR_W-1:0] lbuf_mem [dnle_pkg::ROWS];
    logic [dnle_pkg::BUS_BYTES-1:0][dnle_pkg::CHAR_W-1:0] rd_reg;

    logic [dnle_pkg::LEN_W-1:0]   len_reg, len_next;
    logic [dnle_pkg::TOTAL_W-1:0] total_reg, total_next;
    dnle_pkg::err_t               err_reg, err_next;

    logic [dnle_pkg::LEN_W-1:0]   flen_reg;
    logic [dnle_pkg::NB_W-1:0]    nbytes_reg;
    logic [dnle_pkg::WIDX_W-1:0]  widx_reg;
    logic                         final_reg;
    logic                         lastw_reg;

    logic [dnle_pkg::WORD_W-1:0]  word_reg;
    logic [dnle_pkg::CNT_W-1:0]   cnt_reg;
    logic                         done_reg;
    dnle_pkg::err_t               status_reg;

    logic                         is_dot, append, flush, room, store;
    logic [dnle_pkg::LEN_W-1:0]   len_app;
    logic [dnle_pkg::LEN_W:0]     wpos;
    dnle_pkg::err_t               err_a, err_f;
    logic [dnle_pkg::TOTAL_W:0]   sum;
    logic [dnle_pkg::TOTAL_W-1:0] total_new;
    logic [dnle_pkg::NB_W-1:0]    nbytes;

    logic [dnle_pkg::NB_W-1:0]    base, rem;
    logic [dnle_pkg::WORD_W-1:0]  word_asm;
    logic [dnle_pkg::NB_W-1:0]    pos [dnle_pkg::BUS_BYTES];

    always_comb begin
        is_dot  = (char_in == dnle_pkg::SEP_CHAR);
        append  = !is_dot;
        flush   = is_dot || is_last;
        room    = (len_reg < dnle_pkg::LEN_W'(dnle_pkg::MAX_LABEL));
        store   = cmd.take && append && room;
        len_app = (append && room) ? len_reg + 1'b1 : len_reg;
        wpos    = {1'b0, len_reg} + 1'b1;
        err_a   = (append && !room) ? dnle_pkg::ERR_LABEL : err_reg;
        sum     = {1'b0, total_reg} + (dnle_pkg::TOTAL_W + 1)'(len_app) + 1'b1;
        total_new = (sum > (dnle_pkg::TOTAL_W + 1)'(dnle_pkg::TOTAL_SAT))
                  ? dnle_pkg::TOTAL_W'(dnle_pkg::TOTAL_SAT) : sum[dnle_pkg::TOTAL_W-1:0];
        // room for the terminator is checked at every flush
        err_f   = (err_a == dnle_pkg::ERR_NONE
                   && total_new >= dnle_pkg::TOTAL_W'(dnle_pkg::MAX_NAME))
                ? dnle_pkg::ERR_NAME : err_a;
        nbytes  = dnle_pkg::NB_W'(len_app) + 1'b1 + dnle_pkg::NB_W'(is_last);

        stat.emit      = flush && (err_f == dnle_pkg::ERR_NONE);
        stat.err_out   = is_last && (err_f != dnle_pkg::ERR_NONE);
        stat.last_word = lastw_reg;

        len_next   = len_reg;
        total_next = total_reg;
        err_next   = err_reg;
        if (is_last) begin
            len_next   = '0;
            total_next = '0;
            err_next   = dnle_pkg::ERR_NONE;
        end else if (flush) begin
            len_next   = '0;
            total_next = total_new;
            err_next   = err_f;
        end else begin
            len_next   = len_app;
            err_next   = err_a;
        end
    end

    // word assembly: position 0 is the length byte, past the label reads zero
    always_comb begin
        base = dnle_pkg::NB_W'({widx_reg, {dnle_pkg::LANE_W{1'b0}}});
        rem  = nbytes_reg - base;
        for (int i = 0; i < dnle_pkg::BUS_BYTES; i++) begin
            pos[i] = base + dnle_pkg::NB_W'(i);
            if (pos[i] == '0) begin
                word_asm[i*dnle_pkg::CHAR_W +: dnle_pkg::CHAR_W] = dnle_pkg::CHAR_W'(flen_reg);
            end else if (pos[i] <= dnle_pkg::NB_W'(flen_reg)) begin
                word_asm[i*dnle_pkg::CHAR_W +: dnle_pkg::CHAR_W] = rd_reg[i];
            end else begin
                word_asm[i*dnle_pkg::CHAR_W +: dnle_pkg::CHAR_W] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (store) begin
            lbuf_mem[wpos[dnle_pkg::LEN_W-1:dnle_pkg::LANE_W]][wpos[dnle_pkg::LANE_W-1:0]]
                <= char_in;
        end
        if (cmd.fetch) begin
            rd_reg <= lbuf_mem[widx_reg[dnle_pkg::ROW_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= '0;
            total_reg <= '0;
            err_reg   <= dnle_pkg::ERR_NONE;
            lastw_reg <= 1'b0;
            widx_reg  <= '0;
        end else begin
            if (cmd.take) begin
                len_reg   <= len_next;
                total_reg <= total_next;
                err_reg   <= err_next;
                widx_reg  <= '0;
                if (stat.err_out) begin
                    lastw_reg <= 1'b1;
                end
            end
            if (cmd.load_word) begin
                lastw_reg <= (rem <= dnle_pkg::NB_W'(dnle_pkg::BUS_BYTES));
            end
            if (cmd.advance) begin
                widx_reg <= widx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            flen_reg   <= len_app;
            nbytes_reg <= nbytes;
            final_reg  <= is_last;
            if (stat.err_out) begin
                word_reg   <= '0;
                cnt_reg    <= '0;
                done_reg   <= 1'b1;
                status_reg <= err_f;
            end
        end
        if (cmd.load_word) begin
            word_reg   <= word_asm;
            cnt_reg    <= (rem >= dnle_pkg::NB_W'(dnle_pkg::BUS_BYTES))
                        ? dnle_pkg::CNT_W'(dnle_pkg::BUS_BYTES) : dnle_pkg::CNT_W'(rem);
            done_reg   <= final_reg && (rem <= dnle_pkg::NB_W'(dnle_pkg::BUS_BYTES));
            status_reg <= dnle_pkg::ERR_NONE;
        end
    end

    assign out_word   = word_reg;
    assign byte_count = cnt_reg;
    assign name_done  = done_reg;
    assign status     = status_reg;

endmodule
